[hw/rtl/wfp_pkg.sv]
// ----------------------------------------------------------------------------
// wfp_pkg
// Shared constants and codes for the wall-following PID steering block.
// ----------------------------------------------------------------------------
package wfp_pkg;

	localparam int RANGE_W = 16;
	localparam int GAIN_W  = 16;
	localparam int SPEED_W = 10;
	localparam int OUT_W   = 16;
	localparam int MODE_W  = 3;
	localparam int CIDX_W  = 3;
	localparam int ERR_W   = 17;
	localparam int SUM_W   = 32;

	// drive modes
	localparam logic [MODE_W-1:0] MODE_HOLD   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_RIGHT  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_LEFT   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_TURN   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CRUISE = 3'd4;

	// configuration register indices
	localparam logic [CIDX_W-1:0] REG_GAIN_PROP    = 3'd0;
	localparam logic [CIDX_W-1:0] REG_GAIN_INTEG   = 3'd1;
	localparam logic [CIDX_W-1:0] REG_GAIN_DERIV   = 3'd2;
	localparam logic [CIDX_W-1:0] REG_BASE_SPEED   = 3'd3;
	localparam logic [CIDX_W-1:0] REG_OUTPUT_LIMIT = 3'd4;
	localparam logic [CIDX_W-1:0] REG_SETPOINT_FAR = 3'd5;
	localparam logic [CIDX_W-1:0] REG_SETPOINT_NR  = 3'd6;

	// register reset values
	localparam logic [GAIN_W-1:0]  RST_GAIN_PROP    = 16'd128;
	localparam logic [GAIN_W-1:0]  RST_GAIN_INTEG   = 16'd0;
	localparam logic [GAIN_W-1:0]  RST_GAIN_DERIV   = 16'd0;
	localparam logic [SPEED_W-1:0] RST_BASE_SPEED   = 10'd110;
	localparam logic [SPEED_W-1:0] RST_OUTPUT_LIMIT = 10'd200;
	localparam logic [RANGE_W-1:0] RST_SETPOINT_FAR = 16'd588;
	localparam logic [RANGE_W-1:0] RST_SETPOINT_NR  = 16'd750;

	// range thresholds in mm
	localparam logic [RANGE_W-1:0] RIGHT_NEAR_LIM  = 16'd1500;
	localparam logic [RANGE_W-1:0] RIGHT_DIAG_LIM  = 16'd1000;
	localparam logic [RANGE_W-1:0] LEFT_NEAR_LIM   = 16'd950;
	localparam logic [RANGE_W-1:0] LEFT_SIDE_LIM   = 16'd650;
	localparam logic [RANGE_W-1:0] AHEAD_LIM       = 16'd550;
	localparam logic [RANGE_W-1:0] SWITCH_LIM      = 16'd1000;
	localparam logic [RANGE_W-1:0] CRUISE_SIDE_LIM = 16'd2500;
	localparam logic [RANGE_W-1:0] CRUISE_DIAG_LIM = 16'd2000;
	localparam logic [RANGE_W-1:0] CRUISE_OPEN_LIM = 16'd1000;

	localparam logic signed [OUT_W-1:0] CRUISE_SPEED = 16'sd100;

endpackage

[hw/rtl/wall_follow_pid_steering.sv]
// ----------------------------------------------------------------------------
// wall_follow_pid_steering
// One scan in, one pair of wheel speeds and a drive mode out, via a PID loop
// on the distance to the followed wall, or fixed speeds when turning or cruising.
// ----------------------------------------------------------------------------
// Pipeline: each scan passes through the input register, then the result
// register, where the result is held while the output is stalled.
// Throughput: one scan per cycle while out_stall is low; the PID gain products and
// speed saturation sit between the two registers.
// Reset: PID state and held speeds clear to zero, gains, base speed, limits and
// setpoints take their default values, both channels empty.
module wall_follow_pid_steering (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [wfp_pkg::CIDX_W-1:0]           cfg_index,
	input  logic [wfp_pkg::GAIN_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [wfp_pkg::RANGE_W-1:0]          range_sec0,
	input  logic [wfp_pkg::RANGE_W-1:0]          range_sec1,
	input  logic [wfp_pkg::RANGE_W-1:0]          range_sec4,
	input  logic [wfp_pkg::RANGE_W-1:0]          range_sec5,
	input  logic [wfp_pkg::RANGE_W-1:0]          range_sec6,
	input  logic [wfp_pkg::RANGE_W-1:0]          range_sec8,
	input  logic [wfp_pkg::RANGE_W-1:0]          range_sec10,
	input  logic [wfp_pkg::RANGE_W-1:0]          range_sec11,
	input  logic [wfp_pkg::RANGE_W-1:0]          range_sec13,
	input  logic [wfp_pkg::RANGE_W-1:0]          range_sec14,
	input  logic [wfp_pkg::RANGE_W-1:0]          range_sec16,
	input  logic [wfp_pkg::RANGE_W-1:0]          range_sec17,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [wfp_pkg::OUT_W-1:0]     left_speed,
	output logic signed [wfp_pkg::OUT_W-1:0]     right_speed,
	output logic [wfp_pkg::MODE_W-1:0]           drive_mode
);

	// configuration
	logic [wfp_pkg::GAIN_W-1:0]  gain_prop_q, gain_integ_q, gain_deriv_q;
	logic [wfp_pkg::SPEED_W-1:0] base_speed_q, output_limit_q;
	logic [wfp_pkg::RANGE_W-1:0] setpoint_far_q, setpoint_near_q;

	// input stage
	logic                        valid_s1;
	logic [wfp_pkg::RANGE_W-1:0] s0_s1, s1_s1, s4_s1, s5_s1, s6_s1, s8_s1;
	logic [wfp_pkg::RANGE_W-1:0] s10_s1, s11_s1, s13_s1, s14_s1, s16_s1, s17_s1;

	// PID state
	logic signed [wfp_pkg::SUM_W-1:0] error_sum_q;
	logic signed [wfp_pkg::ERR_W-1:0] last_error_q;

	logic advance;
	logic accept;

	logic right_wall, left_wall, pid_on, turn, cruise;
	logic [wfp_pkg::RANGE_W-1:0] reading, setpoint;
	logic signed [wfp_pkg::ERR_W-1:0] err;
	logic signed [wfp_pkg::SUM_W:0]   sum_wide;
	logic signed [wfp_pkg::SUM_W-1:0] sum_sat;
	logic signed [wfp_pkg::ERR_W:0]   diff;
	logic signed [33:0] p_prop;
	logic signed [48:0] p_integ;
	logic signed [34:0] p_deriv;
	logic signed [50:0] acc;
	logic signed [42:0] u_raw, u_clamp, limit_ext;
	logic signed [44:0] base_ext, plus_u, minus_u;
	logic signed [wfp_pkg::OUT_W-1:0] plus_sat, minus_sat;
	logic signed [wfp_pkg::OUT_W-1:0] left_nx, right_nx, limit_spd;
	logic [wfp_pkg::MODE_W-1:0] mode_nx;

	function automatic logic signed [wfp_pkg::OUT_W-1:0] sat16(input logic signed [44:0] v);
		logic signed [44:0] hi, lo;
		hi = 45'sd32767;
		lo = -45'sd32768;
		if (v > hi)
			return 16'sh7FFF;
		else if (v < lo)
			return 16'sh8000;
		else
			return v[15:0];
	endfunction

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q     <= wfp_pkg::RST_GAIN_PROP;
			gain_integ_q    <= wfp_pkg::RST_GAIN_INTEG;
			gain_deriv_q    <= wfp_pkg::RST_GAIN_DERIV;
			base_speed_q    <= wfp_pkg::RST_BASE_SPEED;
			output_limit_q  <= wfp_pkg::RST_OUTPUT_LIMIT;
			setpoint_far_q  <= wfp_pkg::RST_SETPOINT_FAR;
			setpoint_near_q <= wfp_pkg::RST_SETPOINT_NR;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wfp_pkg::REG_GAIN_PROP:    gain_prop_q     <= cfg_data;
				wfp_pkg::REG_GAIN_INTEG:   gain_integ_q    <= cfg_data;
				wfp_pkg::REG_GAIN_DERIV:   gain_deriv_q    <= cfg_data;
				wfp_pkg::REG_BASE_SPEED:   base_speed_q    <= cfg_data[wfp_pkg::SPEED_W-1:0];
				wfp_pkg::REG_OUTPUT_LIMIT: output_limit_q  <= cfg_data[wfp_pkg::SPEED_W-1:0];
				wfp_pkg::REG_SETPOINT_FAR: setpoint_far_q  <= cfg_data;
				wfp_pkg::REG_SETPOINT_NR:  setpoint_near_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s0_s1  <= range_sec0;
			s1_s1  <= range_sec1;
			s4_s1  <= range_sec4;
			s5_s1  <= range_sec5;
			s6_s1  <= range_sec6;
			s8_s1  <= range_sec8;
			s10_s1 <= range_sec10;
			s11_s1 <= range_sec11;
			s13_s1 <= range_sec13;
			s14_s1 <= range_sec14;
			s16_s1 <= range_sec16;
			s17_s1 <= range_sec17;
		end
	end

	always_comb begin
		right_wall = (s4_s1 < wfp_pkg::RIGHT_NEAR_LIM) || (s1_s1 < wfp_pkg::RIGHT_DIAG_LIM);
		left_wall  = !right_wall &&
			((s13_s1 < wfp_pkg::LEFT_NEAR_LIM) || (s16_s1 < wfp_pkg::LEFT_SIDE_LIM));
		pid_on     = right_wall || left_wall;
		turn       = !right_wall && (s8_s1 < wfp_pkg::AHEAD_LIM);
		cruise     = (s0_s1 > wfp_pkg::CRUISE_SIDE_LIM) && (s17_s1 > wfp_pkg::CRUISE_OPEN_LIM) &&
			(s8_s1 > wfp_pkg::CRUISE_OPEN_LIM) && (s5_s1 > wfp_pkg::CRUISE_DIAG_LIM) &&
			(s11_s1 > wfp_pkg::CRUISE_OPEN_LIM);

		if (right_wall) begin
			if (s4_s1 > wfp_pkg::SWITCH_LIM) begin
				reading  = s1_s1;
				setpoint = setpoint_far_q;
			end else begin
				reading  = s4_s1;
				setpoint = setpoint_near_q;
			end
		end else begin
			if (s13_s1 > wfp_pkg::SWITCH_LIM) begin
				reading  = s16_s1;
				setpoint = setpoint_far_q;
			end else begin
				reading  = s14_s1;
				setpoint = setpoint_near_q;
			end
		end

		err      = $signed({1'b0, setpoint}) - $signed({1'b0, reading});
		sum_wide = {error_sum_q[wfp_pkg::SUM_W-1], error_sum_q} +
			{{(wfp_pkg::SUM_W - wfp_pkg::ERR_W + 1){err[wfp_pkg::ERR_W-1]}}, err};
		if (sum_wide[wfp_pkg::SUM_W] != sum_wide[wfp_pkg::SUM_W-1])
			sum_sat = sum_wide[wfp_pkg::SUM_W] ? {1'b1, {(wfp_pkg::SUM_W-1){1'b0}}}
			                                   : {1'b0, {(wfp_pkg::SUM_W-1){1'b1}}};
		else
			sum_sat = sum_wide[wfp_pkg::SUM_W-1:0];
		diff = {err[wfp_pkg::ERR_W-1], err} - {last_error_q[wfp_pkg::ERR_W-1], last_error_q};

		p_prop  = $signed({1'b0, gain_prop_q}) * err;
		p_integ = $signed({1'b0, gain_integ_q}) * sum_sat;
		p_deriv = $signed({1'b0, gain_deriv_q}) * diff;
		acc     = {{17{p_prop[33]}}, p_prop} + {{2{p_integ[48]}}, p_integ} +
			{{16{p_deriv[34]}}, p_deriv};
		u_raw     = acc[50:8];
		limit_ext = $signed({33'd0, output_limit_q});
		u_clamp   = (u_raw > limit_ext) ? limit_ext : u_raw;

		base_ext  = $signed({35'd0, base_speed_q});
		plus_u    = base_ext + {{2{u_clamp[42]}}, u_clamp};
		minus_u   = base_ext - {{2{u_clamp[42]}}, u_clamp};
		plus_sat  = sat16(plus_u);
		minus_sat = sat16(minus_u);
		limit_spd = $signed({6'd0, output_limit_q});

		left_nx  = left_speed;
		right_nx = right_speed;
		mode_nx  = wfp_pkg::MODE_HOLD;
		if (right_wall) begin
			left_nx  = minus_sat;
			right_nx = plus_sat;
			mode_nx  = wfp_pkg::MODE_RIGHT;
		end else if (left_wall) begin
			left_nx  = plus_sat;
			right_nx = minus_sat;
			mode_nx  = wfp_pkg::MODE_LEFT;
		end
		if (turn) begin
			if (s6_s1 > s10_s1) begin
				left_nx  = limit_spd;
				right_nx = '0;
			end else begin
				left_nx  = '0;
				right_nx = limit_spd;
			end
			mode_nx = wfp_pkg::MODE_TURN;
		end
		if (cruise) begin
			left_nx  = wfp_pkg::CRUISE_SPEED;
			right_nx = wfp_pkg::CRUISE_SPEED;
			mode_nx  = wfp_pkg::MODE_CRUISE;
		end
	end

	// result register doubles as the held speeds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			left_speed   <= '0;
			right_speed  <= '0;
			drive_mode   <= wfp_pkg::MODE_HOLD;
			error_sum_q  <= '0;
			last_error_q <= '0;
		end else begin
			if (advance) begin
				out_valid   <= 1'b1;
				left_speed  <= left_nx;
				right_speed <= right_nx;
				drive_mode  <= mode_nx;
				if (pid_on) begin
					error_sum_q  <= sum_sat;
					last_error_q <= err;
				end
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

[hw/rtl/wfp_checker.sv]
// ----------------------------------------------------------------------------
// wfp_checker
// Port-level checks on the steering block, bound to its top level.
// ----------------------------------------------------------------------------
module wfp_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic signed [wfp_pkg::OUT_W-1:0] left_speed,
	input logic signed [wfp_pkg::OUT_W-1:0] right_speed,
	input logic [wfp_pkg::MODE_W-1:0]       drive_mode
);

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(left_speed) &&
		$stable(right_speed) && $stable(drive_mode))
		else $error("result changed while stalled");

	a_cruise: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_mode == wfp_pkg::MODE_CRUISE |->
		left_speed == wfp_pkg::CRUISE_SPEED && right_speed == wfp_pkg::CRUISE_SPEED)
		else $error("cruise speeds wrong");

	a_turn: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_mode == wfp_pkg::MODE_TURN |->
		(left_speed == '0 || right_speed == '0) && left_speed >= 0 && right_speed >= 0)
		else $error("obstacle turn must stop one wheel");

	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> drive_mode == wfp_pkg::MODE_HOLD || drive_mode == wfp_pkg::MODE_RIGHT ||
		drive_mode == wfp_pkg::MODE_LEFT || drive_mode == wfp_pkg::MODE_TURN ||
		drive_mode == wfp_pkg::MODE_CRUISE)
		else $error("drive mode out of range");

endmodule

bind wall_follow_pid_steering wfp_checker u_wfp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.left_speed  (left_speed),
	.right_speed (right_speed),
	.drive_mode  (drive_mode)
);
